[design/fpa_pkg.sv]
package fpa_pkg;

  localparam int MAX_CHUNKS = 256;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int HEAD_W     = IDX_W + 1;
  localparam int CNT_W      = 9;
  localparam int HANDLE_W   = 9;

  // A head or link value of MAX_CHUNKS marks the end of the free list.
  localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(MAX_CHUNKS);

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_FREE     = 2'd1,
    REQ_FREE_ALL = 2'd2,
    REQ_RSVD     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FILL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [HEAD_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    status_t          status;
  } res_t;

endpackage

[design/fpa_link_ram.sv]
module fpa_link_ram (
  input  logic                     clk,
  input  fpa_pkg::mem_req_t        mem_req,
  output logic [fpa_pkg::HEAD_W-1:0] rd_data
);
  import fpa_pkg::*;

  logic [HEAD_W-1:0] link_mem [MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      link_mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= link_mem[mem_req.raddr];
  end

endmodule

[design/fpa_ctrl.sv]
module fpa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fpa_pkg::req_t                req_type,
  input  logic                         handle_valid,
  input  logic [fpa_pkg::HANDLE_W-1:0] chunk_handle,
  input  logic [fpa_pkg::CNT_W-1:0]    cnt,
  output fpa_pkg::mem_req_t            mem_req,
  input  logic [fpa_pkg::HEAD_W-1:0]   rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output fpa_pkg::res_t                res
);
  import fpa_pkg::*;

  state_t            state_r, state_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0]  fill_r, fill_nxt;
  res_t              res_r, res_nxt;
  logic              fill_last;

  assign fill_last = ({1'b0, fill_r} == CNT_W'(cnt - 1'b1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_ALLOC:    state_nxt = head_r[IDX_W] ? S_RESP : S_ALLOC;
            REQ_FREE_ALL: state_nxt = (cnt == '0) ? S_RESP : S_FILL;
            default:      state_nxt = S_RESP;
          endcase
        end
      end
      S_ALLOC: state_nxt = S_RESP;
      S_FILL: begin
        if (fill_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = fill_r;
    mem_req.wdata = head_r;
    mem_req.raddr = head_r[IDX_W-1:0];
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt.idx    = '0;
          res_nxt.status = ST_OK;
          case (req_type)
            REQ_ALLOC: begin
              if (head_r[IDX_W]) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                res_nxt.idx = head_r[IDX_W-1:0];
              end
            end
            REQ_FREE: begin
              if (!handle_valid) begin
                res_nxt.status = ST_IGNORED;
              end else if (chunk_handle >= HANDLE_W'(cnt)) begin
                res_nxt.status = ST_RANGE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = chunk_handle[IDX_W-1:0];
                head_nxt      = {1'b0, chunk_handle[IDX_W-1:0]};
              end
            end
            REQ_FREE_ALL: begin
              head_nxt = HEAD_EMPTY;
              fill_nxt = '0;
            end
            default: res_nxt.status = ST_IGNORED;
          endcase
        end
      end
      S_ALLOC: begin
        // Registered link of the popped chunk becomes the new head.
        head_nxt = rd_data;
      end
      S_FILL: begin
        mem_req.we = 1'b1;
        head_nxt   = {1'b0, fill_r};
        fill_nxt   = fill_r + 1'b1;
      end
      S_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= HEAD_EMPTY;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

[design/fixed_pool_free_list_allocator_top.sv]
// Channel | Dir | Ports                        | Contents
// in      | in  | in_tvalid/in_tready          | one request
// out     | out | out_tvalid/out_tready        | one result per request
// cfg     | in  | cfg_valid/cfg_ready/cfg_data | pool size, always ready
//
// A free, an ignored request or an allocate on an empty list goes from S_IDLE
// straight to S_RESP; a successful allocate first passes S_ALLOC to read the
// link of the popped chunk. From S_RESP the result goes to the output register.
// Free-all writes one link per cycle in S_FILL, then goes to S_RESP.
// Reset (rst_n, synchronous) empties the free list and sets the pool size to 256.
// A pending result may sit in the output register while the next request is
// accepted and worked on; that request then waits for the output register.
module fixed_pool_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [8:0] chunk_handle, rest zero
  input  logic [2:0]  in_tuser,  // [1:0] req_type, [2] handle_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // [7:0] chunk_index
  output logic [1:0]  out_tuser, // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // pool_size
);
  import fpa_pkg::*;

  logic [CNT_W-1:0]  pool_size_r;
  logic [CNT_W-1:0]  cnt_eff;
  mem_req_t          mem_req;
  logic [HEAD_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= CNT_W'(256);
    end else if (cfg_valid) begin
      pool_size_r <= cfg_data;
    end
  end

  assign cnt_eff = (pool_size_r > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : pool_size_r;

  fpa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (req_t'(in_tuser[1:0])),
    .handle_valid (in_tuser[2]),
    .chunk_handle (in_tdata[HANDLE_W-1:0]),
    .cnt          (cnt_eff),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  fpa_link_ram u_link_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.idx;
  assign out_tuser  = out_r.status;

  // Only a successful allocate hands out a nonzero index.
  a_idx_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("nonzero chunk index on a failed request");

  // The controller never takes a request while a result is waiting on it.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("request accepted while a result is pending");

  // A result the output register cannot take yet stays offered.
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid)
    else $error("pending result dropped");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import fpa_pkg::*;

  typedef struct {
    req_t       kind;
    logic       hv;
    logic [8:0] handle;
  } pool_req_t;

  typedef struct {
    logic [7:0] idx;
    status_t    st;
  } pool_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [8:0] chunk_handle, rest zero
  logic [2:0]  in_tuser = '0;   // [1:0] req_type, [2] handle_valid
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] chunk_index
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;   // pool_size

  fixed_pool_free_list_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the pool as the block should hold it.
  logic [8:0]  link_shadow [MAX_CHUNKS];
  logic [8:0]  head_shadow = HEAD_EMPTY;
  logic [8:0]  count_shadow = 9'd256;

  pool_req_t   req_q [$];
  pool_reply_t replies_due [$];
  logic [7:0]  held_chunks [$];

  int mismatches = 0;
  int req_accepted = 0;
  int flushes = 0;
  int settings_used = 1;
  int seen_status [4] = '{0, 0, 0, 0};

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic pool_apply(input pool_req_t r);
    pool_reply_t rep;
    int          lim;
    lim = (count_shadow > MAX_CHUNKS) ? MAX_CHUNKS : int'(count_shadow);
    rep.idx = '0;
    rep.st  = ST_OK;
    case (r.kind)
      REQ_ALLOC: begin
        if (head_shadow == HEAD_EMPTY) begin
          rep.st = ST_EMPTY;
        end else begin
          rep.idx = head_shadow[7:0];
          held_chunks.push_back(head_shadow[7:0]);
          head_shadow = link_shadow[head_shadow[7:0]];
        end
      end
      REQ_FREE: begin
        // A null handle wins over the range check.
        if (!r.hv) begin
          rep.st = ST_IGNORED;
        end else if (int'(r.handle) >= lim) begin
          rep.st = ST_RANGE;
        end else begin
          link_shadow[r.handle[7:0]] = head_shadow;
          head_shadow = r.handle;
        end
      end
      REQ_FREE_ALL: begin
        flushes++;
        head_shadow = HEAD_EMPTY;
        for (int i = 0; i < lim; i++) begin
          link_shadow[i] = head_shadow;
          head_shadow = 9'(i);
        end
        held_chunks.delete();
      end
      default: rep.st = ST_IGNORED;
    endcase
    replies_due.push_back(rep);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  pool_req_t cur_req;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin : drv
    pool_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      head_shadow = HEAD_EMPTY;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pool_apply(cur_req);
        req_accepted <= req_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          nxt = req_q.pop_front();
          cur_req = nxt;
          in_tdata <= {7'b0, nxt.handle};
          in_tuser <= {nxt.hv, nxt.kind};
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: a randomly redrawn stall mode, plus one long hold.
  int  rx_tick = 0;
  int  stall_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 50 == 0)
        stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && req_accepted >= 220) begin
        // Keep the sender going so the block backs up into its input.
        hold_done = 1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom);
          2: out_tready <= (rx_tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : mon
    pool_reply_t exp_rep;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser !== 2'bxx && !$isunknown(out_tuser))
        seen_status[out_tuser]++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx=%0d status=%0d",
                                  out_tdata, out_tuser));
      end else begin
        exp_rep = replies_due.pop_front();
        if (out_tdata !== exp_rep.idx)
          report_mismatch($sformatf("chunk_index %0d, expected %0d",
                                    out_tdata, exp_rep.idx));
        if (out_tuser !== exp_rep.st)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_tuser, exp_rep.st));
      end
    end
  end

  task automatic queue_req(input req_t k, input logic hv, input logic [8:0] h);
    pool_req_t r;
    r.kind = k;
    r.hv = hv;
    r.handle = h;
    req_q.push_back(r);
  endtask

  // Mostly allocate and give back chunks that were handed out, with some
  // stray handles, null handles, flushes and unused request codes mixed in.
  function automatic pool_req_t random_request();
    pool_req_t r;
    int        pick;
    int        k;
    pick = $urandom_range(0, 99);
    r.hv = 1'($urandom);
    r.handle = 9'($urandom_range(0, 511));
    if (pick < 3) begin
      r.kind = REQ_FREE_ALL;
    end else if (pick < 6) begin
      r.kind = REQ_RSVD;
    end else if (pick < 50 || (pick < 85 && held_chunks.size() == 0)) begin
      r.kind = REQ_ALLOC;
    end else if (pick < 85) begin
      k = $urandom_range(0, held_chunks.size() - 1);
      r.kind = REQ_FREE;
      r.hv = 1'b1;
      r.handle = {1'b0, held_chunks[k]};
      held_chunks.delete(k);
    end else if (pick < 93) begin
      r.kind = REQ_FREE;
    end else begin
      r.kind = REQ_FREE;
      r.hv = 1'b0;
    end
    return r;
  endfunction

  task automatic wait_for_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || replies_due.size() != 0);
  endtask

  task automatic write_pool_size(input logic [8:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_shadow = v;
    settings_used++;
  endtask

  initial begin
    logic [8:0] phase_counts [9];
    phase_counts = '{9'd1, 9'd0, 9'd511, 9'd2, 9'd300, 9'd17, 9'd256,
                     9'($urandom_range(3, 255)), 9'($urandom_range(3, 255))};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Pool starts empty with 256 chunks configured.
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    queue_req(REQ_FREE,     1'b0, 9'h1FF);
    queue_req(REQ_FREE,     1'b1, 9'd256);
    queue_req(REQ_FREE,     1'b1, 9'h1FF);
    queue_req(REQ_FREE,     1'b1, 9'd255);
    queue_req(REQ_FREE,     1'b1, 9'd0);
    queue_req(REQ_FREE,     1'b0, 9'd300);
    queue_req(REQ_ALLOC,    1'b1, 9'h1FF);
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    queue_req(REQ_ALLOC,    1'b1, 9'd0);
    queue_req(REQ_RSVD,     1'b1, 9'd0);
    queue_req(REQ_RSVD,     1'b0, 9'h1FF);
    queue_req(REQ_FREE_ALL, 1'b1, 9'h1FF);
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    // Freeing the same chunk twice loops the list onto itself.
    queue_req(REQ_FREE,     1'b1, 9'd255);
    queue_req(REQ_FREE,     1'b1, 9'd255);
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    queue_req(REQ_ALLOC,    1'b0, 9'd0);
    queue_req(REQ_FREE_ALL, 1'b0, 9'd0);

    for (int p = 0; p < 9; p++) begin
      wait_for_idle();
      write_pool_size(phase_counts[p]);
      // Two phases keep the old list so a new count only moves the range check.
      if (p != 4 && p != 5)
        queue_req(REQ_FREE_ALL, 1'b1, 9'h1FF);
      for (int n = 0; n < 72; n++) begin
        while (req_q.size() >= 4) @(negedge clk);
        req_q.push_back(random_request());
      end
    end

    wait_for_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d requests over %0d chunk counts, including %0d pool flushes.",
             req_accepted, settings_used, flushes);
    $display("Results seen: %0d ok, %0d empty, %0d out of range, %0d ignored.",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3]);
    if (mismatches == 0)
      $display("fixed_pool_free_list_allocator_top test passed");
    else
      $display("fixed_pool_free_list_allocator_top test failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still due.", replies_due.size());
    $display("fixed_pool_free_list_allocator_top test failed");
    $finish;
  end

endmodule

[files.f]
design/fpa_pkg.sv
design/fpa_link_ram.sv
design/fpa_ctrl.sv
design/fixed_pool_free_list_allocator_top.sv
sim/testbench.sv
